// ----- rtl/command_frame_crc32_builder_core_assert.svh -----
// assertion macros used by the checker file
`ifndef COMMAND_FRAME_CRC32_BUILDER_CORE_ASSERT_SVH
`define COMMAND_FRAME_CRC32_BUILDER_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define CFCB_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cfcb same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define CFCB_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cfcb next-cycle check failed");

`endif

// ----- rtl/cfcb_pkg.sv -----
// types, constants and crc helpers of the command frame builder
`timescale 1ns / 1ps

package cfcb_pkg;

  localparam int unsigned FRAME_LEN  = 14;
  localparam int unsigned CRC_COVER  = 10;
  localparam int unsigned PARAM_CNT  = 8;
  localparam int unsigned CRC_SHIFTS = 32;
  localparam int unsigned POS_W      = $clog2(FRAME_LEN);
  localparam int unsigned PIDX_W     = $clog2(PARAM_CNT);

  localparam logic [7:0]  START_BYTE = 8'hF5;
  localparam logic [31:0] CRC_POLY   = 32'h04C11DB7;
  localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
  localparam logic [31:0] CRC_TOP    = 32'h80000000;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic [7:0]                code;
    logic [PARAM_CNT-1:0][7:0] param;
  } cmd_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_t;

  typedef logic [31:0][31:0] crc_mat_t;

  // column j: the effect of register bit j after 32 shifts
  function automatic crc_mat_t crc_mat_f();
    crc_mat_t    m;
    logic [31:0] v;
    for (int j = 0; j < 32; j++) begin
      v = 32'(1) << j;
      for (int k = 0; k < CRC_SHIFTS; k++) begin
        if ((v & CRC_TOP) != 32'd0) begin
          v = (v << 1) ^ CRC_POLY;
        end else begin
          v = v << 1;
        end
      end
      m[j] = v;
    end
    return m;
  endfunction

  localparam crc_mat_t CRC_MAT = crc_mat_f();

  // one byte fed into the low bits, then 32 shifts as a single xor network
  function automatic logic [31:0] crc_word_step(logic [31:0] crc, logic [7:0] data);
    logic [31:0] r;
    logic [31:0] acc;
    r   = crc ^ {24'd0, data};
    acc = '0;
    for (int j = 0; j < 32; j++) begin
      if (r[j]) begin
        acc = acc ^ CRC_MAT[j];
      end
    end
    return acc;
  endfunction

endpackage

// ----- rtl/cfcb_if.sv -----
// handshake channels for commands in and frame bytes out
`timescale 1ns / 1ps

interface cfcb_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] command_code;
  logic [7:0] param_0;
  logic [7:0] param_1;
  logic [7:0] param_2;
  logic [7:0] param_3;
  logic [7:0] param_4;
  logic [7:0] param_5;
  logic [7:0] param_6;
  logic [7:0] param_7;

  modport source (
    output valid, command_code, param_0, param_1, param_2, param_3,
           param_4, param_5, param_6, param_7,
    input  ready
  );
  modport sink (
    input  valid, command_code, param_0, param_1, param_2, param_3,
           param_4, param_5, param_6, param_7,
    output ready
  );
endinterface

interface cfcb_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

// ----- rtl/cfcb_front.sv -----
// front end: takes command items and holds them in a two-entry queue
`timescale 1ns / 1ps

module cfcb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  cfcb_cmd_if.sink            cmd_i,
  output cfcb_pkg::queue_t    q_o,
  input  logic                pop_i
);

  cfcb_pkg::cmd_t mem_q [2];
  cfcb_pkg::cmd_t cmd_in;
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push;
  logic           pop;

  // gather the fields into one command word
  always_comb begin
    cmd_in.code     = cmd_i.command_code;
    cmd_in.param[0] = cmd_i.param_0;
    cmd_in.param[1] = cmd_i.param_1;
    cmd_in.param[2] = cmd_i.param_2;
    cmd_in.param[3] = cmd_i.param_3;
    cmd_in.param[4] = cmd_i.param_4;
    cmd_in.param[5] = cmd_i.param_5;
    cmd_in.param[6] = cmd_i.param_6;
    cmd_in.param[7] = cmd_i.param_7;
  end

  assign cmd_i.ready = (count_q != 2'd2);
  assign push        = cmd_i.valid && cmd_i.ready;
  assign pop         = pop_i && (count_q != 2'd0);

  // queue pointers and fill level
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  assign q_o.valid = (count_q != 2'd0);
  assign q_o.cmd   = mem_q[rd_ptr_q];

endmodule

// ----- rtl/cfcb_back.sv -----
// back end: serializes one frame and folds bytes 0 to 9 into the crc as they leave
`timescale 1ns / 1ps

module cfcb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfcb_pkg::queue_t    q_i,
  output logic                pop_o,
  cfcb_frame_if.source        frame_o
);

  logic                        busy_q, busy_d;
  cfcb_pkg::pos_t              pos_q, pos_d;
  cfcb_pkg::cmd_t              cmd_q;
  logic [31:0]                 crc_q;
  logic [7:0]                  byte_out;
  logic [cfcb_pkg::PIDX_W-1:0] pidx;
  logic [1:0]                  crc_sel;
  logic                        fire;
  logic                        last;
  logic                        load;

  assign pidx    = cfcb_pkg::PIDX_W'(pos_q - cfcb_pkg::pos_t'(2));
  assign crc_sel = 2'(pos_q - cfcb_pkg::pos_t'(cfcb_pkg::CRC_COVER));

  // byte at the current frame position
  always_comb begin
    if (pos_q == cfcb_pkg::pos_t'(0)) begin
      byte_out = cfcb_pkg::START_BYTE;
    end else if (pos_q == cfcb_pkg::pos_t'(1)) begin
      byte_out = cmd_q.code;
    end else if (pos_q < cfcb_pkg::pos_t'(cfcb_pkg::CRC_COVER)) begin
      byte_out = cmd_q.param[pidx];
    end else begin
      byte_out = crc_q[{crc_sel, 3'b000} +: 8];
    end
  end

  assign last  = (pos_q == cfcb_pkg::pos_t'(cfcb_pkg::FRAME_LEN - 1));
  assign fire  = busy_q && frame_o.ready;
  assign load  = q_i.valid && (!busy_q || (fire && last));
  assign pop_o = load;

  // frame position and busy flag
  always_comb begin
    busy_d = busy_q;
    pos_d  = pos_q;
    if (load) begin
      busy_d = 1'b1;
      pos_d  = '0;
    end else if (fire) begin
      if (last) begin
        busy_d = 1'b0;
        pos_d  = '0;
      end else begin
        pos_d = pos_q + cfcb_pkg::pos_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
    end
  end

  // command word and running crc
  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= q_i.cmd;
      crc_q <= cfcb_pkg::CRC_INIT;
    end else if (fire && (pos_q < cfcb_pkg::pos_t'(cfcb_pkg::CRC_COVER))) begin
      crc_q <= cfcb_pkg::crc_word_step(crc_q, byte_out);
    end
  end

  assign frame_o.valid      = busy_q;
  assign frame_o.frame_byte = byte_out;
  assign frame_o.last_byte  = last;

endmodule

// ----- rtl/command_frame_crc32_builder_core.sv -----
// Command frame builder with CRC-32 trailer.
//
// cmd_i takes one command item: a command code and eight parameter bytes.
// frame_o gives the 14-byte frame one byte per item: start byte 0xF5, the
// command code, the eight parameters, then the CRC-32 (poly 0x04C11DB7,
// init all ones, no final xor, word-fed) low byte first. last_byte marks
// byte 13.
// When the output side is free, an accepted command is written into the
// queue and then loaded from it into the back end, which then presents the
// first byte of its frame.
// Throughput: one frame byte per cycle while frame_o.ready is high; the
// single byte output port sets this. The crc folds bytes 0 to 9 as they
// leave through a constant xor network, so bytes 10 to 13 follow with no gap.
// A two-entry queue sits between the front and the back end: commands are
// taken while a frame is still being sent, and cmd_i.ready falls only when
// the queue is full.
// When frame_o.ready is low the current byte holds and the crc pauses.
// Reset empties the queue and drops any frame in flight.
`timescale 1ns / 1ps

module command_frame_crc32_builder_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  cfcb_cmd_if.sink      cmd_i,
  cfcb_frame_if.source  frame_o
);

  cfcb_pkg::queue_t q;
  logic             pop;

  // accept and queue commands
  cfcb_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_i),
    .q_o    (q),
    .pop_i  (pop)
  );

  // build and send frames
  cfcb_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_i     (q),
    .pop_o   (pop),
    .frame_o (frame_o)
  );

endmodule

// ----- rtl/cfcb_checker.sv -----
// port-level checks of the command frame builder and their bind
`timescale 1ns / 1ps
`include "command_frame_crc32_builder_core_assert.svh"

module cfcb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] frame_byte_i,
  input logic       last_byte_i
);

  cfcb_pkg::pos_t pos_q;
  logic [1:0]     pending_q;
  logic           in_fire;
  logic           out_fire;
  logic           frame_done;

  assign in_fire    = in_valid_i && in_ready_i;
  assign out_fire   = out_valid_i && out_ready_i;
  assign frame_done = out_fire && last_byte_i;

  // position within the frame and commands not yet fully sent
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      pending_q <= 2'd0;
    end else begin
      if (out_fire) begin
        pos_q <= (pos_q == cfcb_pkg::pos_t'(cfcb_pkg::FRAME_LEN - 1)) ? '0
                 : pos_q + cfcb_pkg::pos_t'(1);
      end
      pending_q <= pending_q + {1'b0, in_fire} - {1'b0, frame_done};
    end
  end

  // a stalled byte holds
  `CFCB_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(frame_byte_i) && $stable(last_byte_i))

  // last flag only on the fourteenth byte
  `CFCB_ASSERT_IMP(a_last_pos, clk_i, rst_ni, out_fire, last_byte_i == (pos_q == cfcb_pkg::pos_t'(cfcb_pkg::FRAME_LEN - 1)))

  // every frame opens with the start byte
  `CFCB_ASSERT_IMP(a_start_byte, clk_i, rst_ni, out_fire && (pos_q == '0), frame_byte_i == cfcb_pkg::START_BYTE)

  // no output without a command behind it
  `CFCB_ASSERT_IMP(a_no_phantom, clk_i, rst_ni, out_valid_i, pending_q != 2'd0)

  // queue plus the frame in flight bound the commands taken
  `CFCB_ASSERT_IMP(a_no_overfill, clk_i, rst_ni, in_fire, pending_q != 2'd3)

endmodule

bind command_frame_crc32_builder_core cfcb_checker u_cfcb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (cmd_i.valid),
  .in_ready_i   (cmd_i.ready),
  .out_valid_i  (frame_o.valid),
  .out_ready_i  (frame_o.ready),
  .frame_byte_i (frame_o.frame_byte),
  .last_byte_i  (frame_o.last_byte)
);

// ----- tb/tb_command_frame_crc32_builder_core.sv -----
// testbench for the command frame builder: directed and random commands in, bytes checked by a predictor
`timescale 1ns / 1ps

module tb_command_frame_crc32_builder_core;

  localparam int unsigned RANDOM_CMDS    = 280;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_AT_BYTE   = 14 * 30;
  localparam int unsigned HOLD_CYCLES    = 160;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned PRINT_CAP      = 50;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } frame_byte_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_RANDOM,
    RX_PATTERN,
    RX_SPARSE
  } rx_mode_e;

  logic clk_i;
  logic rst_ni;

  cfcb_cmd_if   cmd_ch ();
  cfcb_frame_if frame_ch ();

  command_frame_crc32_builder_core DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_ch),
    .frame_o (frame_ch)
  );

  cfcb_pkg::cmd_t cmd_pending_q[$];
  frame_byte_t    frame_expect_q[$];
  cfcb_pkg::cmd_t offered_cmd;
  int unsigned    burst_left;
  int unsigned    gap_left;
  int unsigned    mismatch_cnt;
  int unsigned    idle_cycles;
  int unsigned    bytes_seen;
  int unsigned    byte_pos;
  int unsigned    hold_left;
  int unsigned    rx_phase_cnt;
  bit             hold_done;
  rx_mode_e       rx_mode;

  // clock
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // known values on every input from time zero
  initial begin
    rst_ni                = 1'b0;
    cmd_ch.valid          = 1'b0;
    cmd_ch.command_code   = '0;
    cmd_ch.param_0        = '0;
    cmd_ch.param_1        = '0;
    cmd_ch.param_2        = '0;
    cmd_ch.param_3        = '0;
    cmd_ch.param_4        = '0;
    cmd_ch.param_5        = '0;
    cmd_ch.param_6        = '0;
    cmd_ch.param_7        = '0;
    frame_ch.ready        = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // word-fed crc: byte into the low bits, then 32 msb-first shifts
  function automatic logic [31:0] crc_fold_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] r;
    r = crc ^ {24'd0, b};
    for (int i = 0; i < 32; i++) begin
      r = r[31] ? ((r << 1) ^ cfcb_pkg::CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  // builds the whole frame of one command and queues its bytes
  function automatic void queue_frame_bytes(cfcb_pkg::cmd_t c);
    logic [7:0]  fb [cfcb_pkg::FRAME_LEN];
    logic [31:0] crc;
    frame_byte_t e;
    crc   = cfcb_pkg::CRC_INIT;
    fb[0] = cfcb_pkg::START_BYTE;
    fb[1] = c.code;
    for (int k = 0; k < cfcb_pkg::PARAM_CNT; k++) begin
      fb[2 + k] = c.param[k];
    end
    for (int k = 0; k < cfcb_pkg::CRC_COVER; k++) begin
      crc = crc_fold_byte(crc, fb[k]);
    end
    fb[10] = crc[7:0];
    fb[11] = crc[15:8];
    fb[12] = crc[23:16];
    fb[13] = crc[31:24];
    for (int k = 0; k < cfcb_pkg::FRAME_LEN; k++) begin
      e.value = fb[k];
      e.last  = (k == cfcb_pkg::FRAME_LEN - 1);
      frame_expect_q.push_back(e);
    end
  endfunction

  task automatic report_mismatch(string field, int unsigned pos, logic [7:0] got,
                                 logic [7:0] want);
    if (mismatch_cnt < PRINT_CAP) begin
      $display("[%0t] mismatch %s at frame position %0d: got %02h, expected %02h",
               $realtime, field, pos, got, want);
    end
    mismatch_cnt++;
  endtask

  // random byte, leaning on the extremes when asked
  function automatic logic [7:0] pick_byte(bit lean_extreme);
    if (lean_extreme && $urandom_range(0, 1)) begin
      return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return 8'($urandom);
  endfunction

  // command driver: bursts of items with random gaps between them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_ch.valid <= 1'b0;
      burst_left   = $urandom_range(1, 24);
      gap_left     = 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        queue_frame_bytes(offered_cmd);
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_ch.valid <= 1'b0;
        end else if (cmd_pending_q.size() != 0) begin
          offered_cmd         = cmd_pending_q.pop_front();
          cmd_ch.valid        <= 1'b1;
          cmd_ch.command_code <= offered_cmd.code;
          cmd_ch.param_0      <= offered_cmd.param[0];
          cmd_ch.param_1      <= offered_cmd.param[1];
          cmd_ch.param_2      <= offered_cmd.param[2];
          cmd_ch.param_3      <= offered_cmd.param[3];
          cmd_ch.param_4      <= offered_cmd.param[4];
          cmd_ch.param_5      <= offered_cmd.param[5];
          cmd_ch.param_6      <= offered_cmd.param[6];
          cmd_ch.param_7      <= offered_cmd.param[7];
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // frame monitor: checks each byte and drives its own stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_ch.ready <= 1'b0;
      bytes_seen     = 0;
      byte_pos       = 0;
      hold_left      = 0;
      hold_done      = 1'b0;
      rx_phase_cnt   = 0;
      rx_mode        = RX_FREE;
    end else begin
      if (frame_ch.valid && frame_ch.ready) begin
        if (frame_expect_q.size() == 0) begin
          report_mismatch("unexpected byte", byte_pos, frame_ch.frame_byte, 8'h00);
        end else begin
          frame_byte_t e;
          e = frame_expect_q.pop_front();
          if (frame_ch.frame_byte !== e.value) begin
            report_mismatch("frame_byte", byte_pos, frame_ch.frame_byte, e.value);
          end
          if (frame_ch.last_byte !== e.last) begin
            report_mismatch("last_byte", byte_pos, {7'd0, frame_ch.last_byte},
                            {7'd0, e.last});
          end
        end
        byte_pos = (byte_pos == cfcb_pkg::FRAME_LEN - 1) ? 0 : byte_pos + 1;
        bytes_seen++;
      end

      // one long hold-off so the command queue fills and backs up
      if (!hold_done && bytes_seen >= HOLD_AT_BYTE) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end

      rx_phase_cnt++;
      if (rx_phase_cnt >= 64) begin
        rx_phase_cnt = 0;
        rx_mode      = rx_mode_e'($urandom_range(0, 3));
      end

      if (hold_left > 0) begin
        hold_left--;
        frame_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:    frame_ch.ready <= 1'b1;
          RX_RANDOM:  frame_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_PATTERN: frame_ch.ready <= ((rx_phase_cnt % 5) != 2);
          default:    frame_ch.ready <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  // cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((cmd_ch.valid && cmd_ch.ready) || (frame_ch.valid && frame_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    idle_cycles = 0;
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // stimulus and end of run
  initial begin
    cfcb_pkg::cmd_t c;
    bit             lean;
    mismatch_cnt = 0;

    // directed: extremes, alternating patterns, walking ones
    cmd_pending_q.push_back({8'h00, 64'h0000_0000_0000_0000});
    cmd_pending_q.push_back({8'hFF, 64'hFFFF_FFFF_FFFF_FFFF});
    cmd_pending_q.push_back({8'h00, 64'hFFFF_FFFF_FFFF_FFFF});
    cmd_pending_q.push_back({8'hFF, 64'h0000_0000_0000_0000});
    cmd_pending_q.push_back({8'hAA, 64'h5555_5555_5555_5555});
    cmd_pending_q.push_back({8'h55, 64'hAAAA_AAAA_AAAA_AAAA});
    cmd_pending_q.push_back({8'h01, 64'h0908_0706_0504_0302});
    cmd_pending_q.push_back({8'h80, 64'h8080_8080_8080_8080});
    for (int k = 0; k < 8; k++) begin
      c.code = 8'(1) << k;
      c.param = 64'(1) << (9 * k);
      cmd_pending_q.push_back(c);
    end

    // random commands, some leaning on all-zero and all-one bytes
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      lean   = ($urandom_range(0, 7) == 0);
      c.code = pick_byte(lean);
      for (int k = 0; k < cfcb_pkg::PARAM_CNT; k++) begin
        c.param[k] = pick_byte(lean);
      end
      cmd_pending_q.push_back(c);
    end

    @(posedge rst_ni);
    while (cmd_pending_q.size() != 0 || cmd_ch.valid) begin
      @(posedge clk_i);
    end
    while (frame_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
